[hw/rtl/gsls_pkg.sv]
// Package for the Gauss-Seidel Laplace sweep block: sizes, codes and word types.
package gsls_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int CELL_W    = 24;
   localparam int SUM_W     = CELL_W + 2;
   localparam int SIZE_W    = 7;
   localparam int PASS_W    = 16;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_SWEEP = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_SLICE = 3'd0,
      CSR_LAST_SLICE  = 3'd1,
      CSR_ROWS_IN_USE = 3'd2,
      CSR_COLS_IN_USE = 3'd3,
      CSR_SWEEP_COUNT = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_ROW,
      ST_UP,
      ST_DN,
      ST_LT,
      ST_RT,
      ST_WR
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic signed [CELL_W-1:0] cell_value;
   } req_word_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] read_value;
      logic                     status;
   } rsp_word_type;

endpackage

[hw/rtl/gauss_seidel_laplace_sweep.sv]
// Gauss-Seidel Laplace sweep block: grid store, sweep sequencer and shared adder.
//
// Usage:
//  - req_ channel carries one command word: write cell, run sweeps, read cell.
//    Every accepted word gives exactly one rsp_ word (read_value, status).
//  - csr_ channel writes the slice flags, grid size and pass count; it is
//    always ready and is only to be written while the block is idle.
//  - Write cell, bad addresses and the unused code: the response is loaded
//    in the accepting cycle, so one word per cycle is sustained while rsp_ready is high.
//  - Read cell: the value passes the registered RAM read port, then ST_RD_WAIT.
//  - Run sweeps: each interior cell steps through UP, DN, LT and RT (four
//    neighbour reads through the single RAM read port, summed by one shared
//    adder), then WR for the write-back; ROW opens each row; sweep_count passes.
//  - req_ready is high only when the sequencer is idle and the response
//    register is empty or being emptied; a stalled rsp_ holds the block.
//  - Reset restores the register defaults and empties the response slot.
//    The grid RAM is not cleared: cells are undefined until written.
//  - Row skips: row 1 is held when first_slice is set, the next-to-last row
//    when last_slice is set; halo rows and edge columns are never updated.
module gauss_seidel_laplace_sweep (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gsls_pkg::req_word_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gsls_pkg::rsp_word_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gsls_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gsls_pkg::CSR_DAT_W-1:0]       csr_data
);

   // config registers
   logic                          first_ff;
   logic                          last_ff;
   logic [gsls_pkg::SIZE_W-1:0]   rows_ff;
   logic [gsls_pkg::SIZE_W-1:0]   cols_ff;
   logic [gsls_pkg::PASS_W-1:0]   passes_ff;

   // sequencer state
   gsls_pkg::state_type           state_ff, state_in;
   logic [gsls_pkg::ROW_W-1:0]    r_ff, r_in;
   logic [gsls_pkg::COL_W-1:0]    c_ff, c_in;
   logic [gsls_pkg::PASS_W-1:0]   pass_ff, pass_in;
   logic signed [gsls_pkg::SUM_W-1:0] acc_ff, acc_in;

   // response slot
   logic                          rsp_valid_ff, rsp_valid_in;
   gsls_pkg::rsp_word_type        rsp_ff, rsp_in;

   // grid RAM
   logic signed [gsls_pkg::CELL_W-1:0] grid_mem [0:(1 << gsls_pkg::ADDR_W)-1];
   logic signed [gsls_pkg::CELL_W-1:0] rdata_ff;
   logic [gsls_pkg::ADDR_W-1:0]   raddr;
   logic [gsls_pkg::ADDR_W-1:0]   waddr;
   logic signed [gsls_pkg::CELL_W-1:0] wdata;
   logic                          we;

   // derived sizes
   logic [gsls_pkg::SIZE_W-1:0]   nr;
   logic [gsls_pkg::SIZE_W-1:0]   nc;
   logic                          req_fire;
   logic                          slot_free;
   logic                          addr_bad;
   logic                          row_end;
   logic                          row_skip;
   logic                          col_last;
   logic                          pass_last;
   logic signed [gsls_pkg::SUM_W-1:0] add_a;
   logic signed [gsls_pkg::SUM_W-1:0] add_sum;

   localparam logic [gsls_pkg::SIZE_W-1:0] SizeMin  = gsls_pkg::SIZE_W'(3);
   localparam logic [gsls_pkg::SIZE_W-1:0] RowsMax  = gsls_pkg::SIZE_W'(gsls_pkg::MAX_ROWS);
   localparam logic [gsls_pkg::SIZE_W-1:0] ColsMax  = gsls_pkg::SIZE_W'(gsls_pkg::MAX_COLS);

   // sizes saturated to the usable range
   always_comb begin
      priority if (rows_ff < SizeMin) nr = SizeMin;
      else if (rows_ff > RowsMax)     nr = RowsMax;
      else                            nr = rows_ff;
      priority if (cols_ff < SizeMin) nc = SizeMin;
      else if (cols_ff > ColsMax)     nc = ColsMax;
      else                            nc = cols_ff;
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == gsls_pkg::ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign addr_bad  = ({1'b0, req_data.row} >= nr) || ({1'b0, req_data.col} >= nc);
   assign row_end   = ({1'b0, r_ff} + gsls_pkg::SIZE_W'(1)) >= nr;
   assign row_skip  = (first_ff && (r_ff == gsls_pkg::ROW_W'(1)))
                   || (last_ff && ({1'b0, r_ff} == nr - gsls_pkg::SIZE_W'(2)));
   assign col_last  = ({1'b0, c_ff} + gsls_pkg::SIZE_W'(2)) >= nc;
   assign pass_last = (pass_ff + gsls_pkg::PASS_W'(1)) == passes_ff;

   // the one shared adder: first neighbour starts from zero
   assign add_a   = (state_ff == gsls_pkg::ST_DN) ? '0 : acc_ff;
   assign add_sum = add_a + gsls_pkg::SUM_W'(rdata_ff);

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      pass_in      = pass_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      raddr        = {req_data.row, req_data.col};
      waddr        = {r_ff, c_ff};
      wdata        = add_sum[gsls_pkg::SUM_W-1:2];
      we           = 1'b0;

      unique case (state_ff)
         gsls_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_in.read_value = '0;
               rsp_in.status     = 1'b0;
               unique case (gsls_pkg::func_type'(req_data.func))
                  gsls_pkg::FUNC_WRITE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = addr_bad;
                     we            = !addr_bad;
                     waddr         = {req_data.row, req_data.col};
                     wdata         = req_data.cell_value;
                  end
                  gsls_pkg::FUNC_READ: begin
                     if (addr_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = 1'b1;
                     end else begin
                        state_in = gsls_pkg::ST_RD_WAIT;
                     end
                  end
                  gsls_pkg::FUNC_SWEEP: begin
                     if (passes_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = gsls_pkg::ST_ROW;
                        r_in     = gsls_pkg::ROW_W'(1);
                        pass_in  = '0;
                     end
                  end
                  gsls_pkg::FUNC_NONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         gsls_pkg::ST_RD_WAIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in.read_value = rdata_ff;
            rsp_in.status     = 1'b0;
            state_in          = gsls_pkg::ST_IDLE;
         end
         gsls_pkg::ST_ROW: begin
            priority if (row_end) begin
               if (pass_last) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.read_value = '0;
                  rsp_in.status     = 1'b0;
                  state_in          = gsls_pkg::ST_IDLE;
               end else begin
                  pass_in = pass_ff + gsls_pkg::PASS_W'(1);
                  r_in    = gsls_pkg::ROW_W'(1);
               end
            end else if (row_skip) begin
               r_in = r_ff + gsls_pkg::ROW_W'(1);
            end else begin
               c_in     = gsls_pkg::COL_W'(1);
               state_in = gsls_pkg::ST_UP;
            end
         end
         gsls_pkg::ST_UP: begin
            raddr    = {r_ff - gsls_pkg::ROW_W'(1), c_ff};
            state_in = gsls_pkg::ST_DN;
         end
         gsls_pkg::ST_DN: begin
            raddr    = {r_ff + gsls_pkg::ROW_W'(1), c_ff};
            acc_in   = add_sum;
            state_in = gsls_pkg::ST_LT;
         end
         gsls_pkg::ST_LT: begin
            raddr    = {r_ff, c_ff - gsls_pkg::COL_W'(1)};
            acc_in   = add_sum;
            state_in = gsls_pkg::ST_RT;
         end
         gsls_pkg::ST_RT: begin
            raddr    = {r_ff, c_ff + gsls_pkg::COL_W'(1)};
            acc_in   = add_sum;
            state_in = gsls_pkg::ST_WR;
         end
         gsls_pkg::ST_WR: begin
            // floor of quarter sum is the arithmetic shift by two
            we = 1'b1;
            if (col_last) begin
               r_in     = r_ff + gsls_pkg::ROW_W'(1);
               state_in = gsls_pkg::ST_ROW;
            end else begin
               c_in     = c_ff + gsls_pkg::COL_W'(1);
               state_in = gsls_pkg::ST_UP;
            end
         end
         default: state_in = gsls_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsls_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff    <= r_in;
      c_ff    <= c_in;
      pass_ff <= pass_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 1'b1;
         last_ff   <= 1'b1;
         rows_ff   <= gsls_pkg::SIZE_W'(12);
         cols_ff   <= gsls_pkg::SIZE_W'(10);
         passes_ff <= gsls_pkg::PASS_W'(200);
      end else if (csr_valid && csr_ready) begin
         unique case (gsls_pkg::csr_index_type'(csr_index))
            gsls_pkg::CSR_FIRST_SLICE: first_ff  <= csr_data[0];
            gsls_pkg::CSR_LAST_SLICE:  last_ff   <= csr_data[0];
            gsls_pkg::CSR_ROWS_IN_USE: rows_ff   <= csr_data[gsls_pkg::SIZE_W-1:0];
            gsls_pkg::CSR_COLS_IN_USE: cols_ff   <= csr_data[gsls_pkg::SIZE_W-1:0];
            gsls_pkg::CSR_SWEEP_COUNT: passes_ff <= csr_data[gsls_pkg::PASS_W-1:0];
            default: ;
         endcase
      end
   end

   // grid RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         grid_mem[waddr] <= wdata;
      end
      rdata_ff <= grid_mem[raddr];
   end

endmodule

[tb/sv/tb_gauss_seidel_laplace_sweep.sv]
// Self-checking testbench for the Gauss-Seidel Laplace sweep block.
`timescale 1ns / 1ps

module tb_gauss_seidel_laplace_sweep;

   // Idle cycles allowed with no handshake at all, on top of any sweep time in flight.
   localparam int QUIET_BASE = 5000;
   localparam int N_PHASES   = 10;
   // Responses seen before the receiver's one long hold-off.
   localparam int LONG_HOLD_AT = 400;
   localparam int LONG_HOLD    = 500;

   // Slice setting as held by the csr_ registers.
   typedef struct {
      bit                          first;
      bit                          last;
      logic [gsls_pkg::SIZE_W-1:0] rows;
      logic [gsls_pkg::SIZE_W-1:0] cols;
      logic [gsls_pkg::PASS_W-1:0] passes;
   } setting_type;

   // One line of the directed plan: either a new setting or one command word,
   // optionally with its response typed in by hand.
   typedef struct {
      bit                     is_cfg;
      setting_type            set;
      gsls_pkg::req_word_type cmd;
      bit                     typed;
      gsls_pkg::rsp_word_type typed_word;
   } plan_row_type;

   // Response word still owed by the block, plus the sweep time it may take.
   typedef struct {
      gsls_pkg::rsp_word_type word;
      int                     allow;
   } awaited_type;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   gsls_pkg::req_word_type         req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   gsls_pkg::rsp_word_type         rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [gsls_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gsls_pkg::CSR_DAT_W-1:0] csr_data  = '0;

   // Shadow of the block: registers (reset values), grid contents and which
   // cells hold a written value. The RAM is never cleared, so neither is this.
   setting_type cur_set = '{first: 1'b1, last: 1'b1, rows: 7'd12, cols: 7'd10,
                            passes: 16'd200};
   logic signed [gsls_pkg::CELL_W-1:0] grid_model [gsls_pkg::MAX_ROWS][gsls_pkg::MAX_COLS];
   bit                                 grid_known [gsls_pkg::MAX_ROWS][gsls_pkg::MAX_COLS];

   awaited_type awaited_words[$];
   int       sweep_allow  = 0;
   int       quiet_cycles = 0;
   int       n_errors     = 0;
   int       rsp_count    = 0;
   int       n_write = 0, n_read = 0, n_sweep = 0, n_bad = 0, n_none = 0, n_settings = 0;

   // Sender pacing state.
   bit offering   = 1'b0;
   int burst_left = 0;

   gauss_seidel_laplace_sweep dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Behaviour of the block, applied to the shadow state
   // ------------------------------------------------------------------

   function automatic int dim_in_use(logic [gsls_pkg::SIZE_W-1:0] v, int hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   // Applies one accepted command word and returns the response it owes.
   function automatic gsls_pkg::rsp_word_type grid_apply(gsls_pkg::req_word_type w);
      gsls_pkg::rsp_word_type             r;
      logic signed [gsls_pkg::SUM_W-1:0]  acc;
      int                                 nr, nc;
      r  = '0;
      nr = dim_in_use(cur_set.rows, gsls_pkg::MAX_ROWS);
      nc = dim_in_use(cur_set.cols, gsls_pkg::MAX_COLS);
      case (w.func)
         gsls_pkg::FUNC_SWEEP: begin
            // in place, row-major, so each cell sees its newest neighbours
            for (int p = 0; p < int'(cur_set.passes); p++) begin
               for (int ri = 1; ri < nr - 1; ri++) begin
                  if (cur_set.first && ri == 1) continue;
                  if (cur_set.last && ri == nr - 2) continue;
                  for (int ci = 1; ci < nc - 1; ci++) begin
                     acc = grid_model[ri-1][ci];
                     acc = acc + grid_model[ri+1][ci] + grid_model[ri][ci-1]
                         + grid_model[ri][ci+1];
                     // floor of a quarter: arithmetic shift, always fits the cell
                     grid_model[ri][ci] = gsls_pkg::CELL_W'(acc >>> 2);
                  end
               end
            end
         end
         gsls_pkg::FUNC_WRITE, gsls_pkg::FUNC_READ: begin
            if (w.row >= nr || w.col >= nc) begin
               r.status = 1'b1;
            end else if (w.func == gsls_pkg::FUNC_WRITE) begin
               grid_model[w.row][w.col] = w.cell_value;
               grid_known[w.row][w.col] = 1'b1;
            end else begin
               r.read_value = grid_model[w.row][w.col];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [gsls_pkg::CELL_W-1:0] rand_cell();
      case ($urandom_range(0, 7))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         2:       return gsls_pkg::CELL_W'(int'($urandom_range(0, 8191)) - 4096);
         default: return gsls_pkg::CELL_W'($urandom);
      endcase
   endfunction

   function automatic int rand_dim();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 2);
         1:       return $urandom_range(13, 16);
         default: return $urandom_range(3, 12);
      endcase
   endfunction

   function automatic setting_type slice_setting(bit fs, bit ls, int rows, int cols,
                                                 int passes);
      setting_type s;
      s.first  = fs;
      s.last   = ls;
      s.rows   = gsls_pkg::SIZE_W'(rows);
      s.cols   = gsls_pkg::SIZE_W'(cols);
      s.passes = gsls_pkg::PASS_W'(passes);
      return s;
   endfunction

   function automatic plan_row_type set_row(bit fs, bit ls, int rows, int cols, int passes);
      plan_row_type p;
      p.is_cfg = 1'b1;
      p.set    = slice_setting(fs, ls, rows, cols, passes);
      p.typed  = 1'b0;
      return p;
   endfunction

   function automatic plan_row_type step_row(gsls_pkg::func_type f, int r, int c, int v,
                                             bit typed = 1'b0, int rv = 0, bit st = 1'b0);
      plan_row_type p;
      p.is_cfg                = 1'b0;
      p.cmd.func              = f;
      p.cmd.row               = gsls_pkg::ROW_W'(r);
      p.cmd.col               = gsls_pkg::COL_W'(c);
      p.cmd.cell_value        = gsls_pkg::CELL_W'(v);
      p.typed                 = typed;
      p.typed_word.read_value = gsls_pkg::CELL_W'(rv);
      p.typed_word.status     = st;
      return p;
   endfunction

   task automatic drop_valid();
      if (offering) begin
         req_valid <= 1'b0;
         offering  = 1'b0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken.
   // The owed response is worked out at acceptance, when the shadow is in step.
   task automatic offer(input gsls_pkg::req_word_type w, input bit typed,
                        input gsls_pkg::rsp_word_type typed_word);
      awaited_type a;
      int          nr, nc;
      req_data  <= w;
      req_valid <= 1'b1;
      offering  = 1'b1;
      do @(posedge clock); while (!req_ready);
      nr      = dim_in_use(cur_set.rows, gsls_pkg::MAX_ROWS);
      nc      = dim_in_use(cur_set.cols, gsls_pkg::MAX_COLS);
      a.allow = 0;
      if (w.func == gsls_pkg::FUNC_SWEEP)
         a.allow = 3 * (int'(cur_set.passes) * ((nr - 2) * (nc - 2) * 5 + nr + 2) + 16);
      a.word = grid_apply(w);
      if (a.word.status)                       n_bad++;
      else if (w.func == gsls_pkg::FUNC_WRITE) n_write++;
      else if (w.func == gsls_pkg::FUNC_READ)  n_read++;
      else if (w.func == gsls_pkg::FUNC_SWEEP) n_sweep++;
      else                                     n_none++;
      if (typed) a.word = typed_word;
      sweep_allow += a.allow;
      awaited_words.push_back(a);
      @(negedge clock);
   endtask

   // Bursts of random length, random gaps between them, now and then a long
   // run with no gap at all.
   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
      end
   endtask

   // Sender stops and waits for every owed word before the block is touched.
   task automatic wait_idle();
      drop_valid();
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_put(input gsls_pkg::csr_index_type idx,
                          input logic [gsls_pkg::CSR_DAT_W-1:0] v);
      csr_index <= idx;
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gsls_pkg::CSR_FIRST_SLICE: cur_set.first  = v[0];
         gsls_pkg::CSR_LAST_SLICE:  cur_set.last   = v[0];
         gsls_pkg::CSR_ROWS_IN_USE: cur_set.rows   = v[gsls_pkg::SIZE_W-1:0];
         gsls_pkg::CSR_COLS_IN_USE: cur_set.cols   = v[gsls_pkg::SIZE_W-1:0];
         gsls_pkg::CSR_SWEEP_COUNT: cur_set.passes = v[gsls_pkg::PASS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input setting_type s);
      wait_idle();
      csr_put(gsls_pkg::CSR_FIRST_SLICE, gsls_pkg::CSR_DAT_W'(s.first));
      csr_put(gsls_pkg::CSR_LAST_SLICE,  gsls_pkg::CSR_DAT_W'(s.last));
      csr_put(gsls_pkg::CSR_ROWS_IN_USE, gsls_pkg::CSR_DAT_W'(s.rows));
      csr_put(gsls_pkg::CSR_COLS_IN_USE, gsls_pkg::CSR_DAT_W'(s.cols));
      csr_put(gsls_pkg::CSR_SWEEP_COUNT, gsls_pkg::CSR_DAT_W'(s.passes));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // A sweep reads every cell of the slice in use; the RAM is undefined until
   // written, so any cell not yet written gets a random value first.
   task automatic fill_unknown();
      gsls_pkg::req_word_type w;
      int                     nr, nc;
      nr = dim_in_use(cur_set.rows, gsls_pkg::MAX_ROWS);
      nc = dim_in_use(cur_set.cols, gsls_pkg::MAX_COLS);
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            if (!grid_known[r][c]) begin
               w.func       = gsls_pkg::FUNC_WRITE;
               w.row        = gsls_pkg::ROW_W'(r);
               w.col        = gsls_pkg::COL_W'(c);
               w.cell_value = rand_cell();
               offer(w, 1'b0, '0);
               pace();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus: directed plan, then random phases
   // ------------------------------------------------------------------

   initial begin : stimulus
      plan_row_type           plan[$];
      setting_type            s;
      gsls_pkg::req_word_type w;
      int                     nr, nc, pick, n_items;
      bit                     big;

      // Reset values first: 12 rows, 10 columns, both slice flags set, 200 passes.
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 0, 0, -8388608, 1'b1, 0, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 0, 0, 0, 1'b1, 'h800000, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 11, 9, 8388607, 1'b1, 0, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 11, 9, 0, 1'b1, 'h7FFFFF, 1'b0));
      // first row and column past the area in use, then the far corner
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 12, 0, 5, 1'b1, 0, 1'b1));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 0, 10, 0, 1'b1, 0, 1'b1));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 63, 63, 0, 1'b1, 0, 1'b1));
      // unused code: no effect, clean status
      plan.push_back(step_row(gsls_pkg::FUNC_NONE, 63, 63, -1, 1'b1, 0, 1'b0));
      // sizes below the floor clamp to 3x3; zero passes leaves the grid alone
      plan.push_back(set_row(1'b0, 1'b0, 0, 2, 0));
      plan.push_back(step_row(gsls_pkg::FUNC_SWEEP, 5, 5, 7, 1'b1, 0, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 1, 1, 0));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 0, 3, 1, 1'b1, 0, 1'b1));
      // one pass: a quarter of -1 floors to -1
      plan.push_back(set_row(1'b0, 1'b0, 0, 2, 1));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 0, 1, -1));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 2, 1, 0));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 1, 0, 0));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 1, 2, 0));
      plan.push_back(step_row(gsls_pkg::FUNC_SWEEP, 0, 0, 0, 1'b1, 0, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 1, 1, 0, 1'b1, 'hFFFFFF, 1'b0));
      // four neighbours at the most negative value: the widest negative sum
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 0, 1, -8388608));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 2, 1, -8388608));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 1, 0, -8388608));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 1, 2, -8388608));
      plan.push_back(step_row(gsls_pkg::FUNC_SWEEP, 0, 0, 0, 1'b1, 0, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 1, 1, 0, 1'b1, 'h800000, 1'b0));
      // first slice on three rows: the only interior row is fixed
      plan.push_back(set_row(1'b1, 1'b0, 3, 3, 1));
      plan.push_back(step_row(gsls_pkg::FUNC_WRITE, 0, 1, 8388607));
      plan.push_back(step_row(gsls_pkg::FUNC_SWEEP, 0, 0, 0, 1'b1, 0, 1'b0));
      plan.push_back(step_row(gsls_pkg::FUNC_READ, 1, 1, 0, 1'b1, 'h800000, 1'b0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         if (plan[k].is_cfg) begin
            apply_setting(plan[k].set);
         end else begin
            if (plan[k].cmd.func == gsls_pkg::FUNC_SWEEP) fill_unknown();
            offer(plan[k].cmd, plan[k].typed, plan[k].typed_word);
            pace();
         end
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0:       s = slice_setting(1'b1, 1'b0, 127, 3, 3);   // rows clamp to the top
            1:       s = slice_setting(1'b0, 1'b1, 3, 127, 2);   // columns clamp to the top
            2:       s = slice_setting(1'b1, 1'b1, 3, 3, 65535); // longest pass count
            3:       s = slice_setting(1'b0, 1'b0, 2, 1, 1);
            default: s = slice_setting($urandom_range(0, 1), $urandom_range(0, 1),
                                       rand_dim(), rand_dim(), $urandom_range(1, 4));
         endcase
         apply_setting(s);
         fill_unknown();
         nr      = dim_in_use(cur_set.rows, gsls_pkg::MAX_ROWS);
         nc      = dim_in_use(cur_set.cols, gsls_pkg::MAX_COLS);
         big     = (cur_set.passes > 64);
         n_items = big ? 20 : 70;
         for (int i = 0; i < n_items; i++) begin
            w.row        = gsls_pkg::ROW_W'($urandom_range(0, gsls_pkg::MAX_ROWS - 1));
            w.col        = gsls_pkg::COL_W'($urandom_range(0, gsls_pkg::MAX_COLS - 1));
            w.cell_value = rand_cell();
            pick         = $urandom_range(0, 99);
            // the long setting gets exactly one sweep
            if (big) pick = (i == 10) ? 99 : pick % 94;
            if (pick < 76) begin
               w.func = (pick < 38) ? gsls_pkg::FUNC_WRITE : gsls_pkg::FUNC_READ;
               w.row  = gsls_pkg::ROW_W'($urandom_range(0, nr - 1));
               w.col  = gsls_pkg::COL_W'($urandom_range(0, nc - 1));
            end else if (pick < 88) begin
               w.func = (pick < 82) ? gsls_pkg::FUNC_WRITE : gsls_pkg::FUNC_READ;
               if (nr < gsls_pkg::MAX_ROWS
                   && (nc == gsls_pkg::MAX_COLS || $urandom_range(0, 1) == 1))
                  w.row = gsls_pkg::ROW_W'($urandom_range(nr, gsls_pkg::MAX_ROWS - 1));
               else
                  w.col = gsls_pkg::COL_W'($urandom_range(nc, gsls_pkg::MAX_COLS - 1));
            end else if (pick < 94) begin
               w.func = gsls_pkg::FUNC_NONE;
            end else begin
               w.func = gsls_pkg::FUNC_SWEEP;
            end
            offer(w, 1'b0, '0);
            pace();
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("tb: %0d settings; %0d writes, %0d reads, %0d sweeps, %0d out of range, %0d unused",
               n_settings, n_write, n_read, n_sweep, n_bad, n_none);
      $display("tb: %0d response words checked, %0d mismatches", rsp_count, n_errors);
      if (n_errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: mode changes after spans of random length; once, a long hold-off
   // while the sender keeps offering, so the block backs up onto req_ready.
   // ------------------------------------------------------------------

   initial begin : rsp_sink
      int mode, span, left;
      bit level, held_long;
      mode      = 0;
      span      = 0;
      left      = 0;
      level     = 1'b1;
      held_long = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_long && rsp_count >= LONG_HOLD_AT) begin
            held_long = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(100, 300);
            end else begin
               span--;
            end
            case (mode)
               0: level = 1'b1;
               1: level = $urandom_range(0, 1);
               2: level = ($urandom_range(0, 9) != 0);
               default: begin
                  // stall/flow runs of random length
                  if (left == 0) begin
                     level = !level;
                     left  = $urandom_range(1, 12);
                  end else begin
                     left--;
                  end
               end
            endcase
            rsp_ready <= level;
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: every accepted rsp_ word against the oldest owed word
   // ------------------------------------------------------------------

   always @(posedge clock) begin : rsp_check
      awaited_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_words.size() == 0) begin
            $error("rsp word with nothing owed: read_value %h status %0d",
                   rsp_data.read_value, rsp_data.status);
            n_errors++;
         end else begin
            head = awaited_words.pop_front();
            sweep_allow -= head.allow;
            rsp_count++;
            if (rsp_data.read_value !== head.word.read_value) begin
               $error("read_value: expected %h, got %h", head.word.read_value,
                      rsp_data.read_value);
               n_errors++;
            end
            if (rsp_data.status !== head.word.status) begin
               $error("status: expected %0d, got %0d", head.word.status, rsp_data.status);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: cycles with no handshake on any channel; a sweep in flight
   // widens the allowance by its worst-case run time.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles > QUIET_BASE + sweep_allow) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
